[rtl/isr_pkg.sv]
`default_nettype none

package isr_pkg;

    localparam int DATA_W     = 32;
    localparam int STEP_W     = 16;
    localparam int THRESH_W   = 16;
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_METHOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    localparam logic                METHOD_RST = 1'b1;
    localparam logic [THRESH_W-1:0] THRESH_RST = 16'd1;
    localparam logic [STEP_W-1:0]   LIMIT_RST  = 16'd10000;

    localparam logic METHOD_DIRECT = 1'b0;
    localparam logic METHOD_HERON  = 1'b1;

    localparam logic [STEP_W-1:0] CAPTURE_FIRST  = 16'd2;
    localparam logic [STEP_W-1:0] CAPTURE_SECOND = 16'd10;

    typedef struct packed {
        logic signed [DATA_W-1:0] radicand;
        logic signed [DATA_W-1:0] start_value;
    } operand_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [STEP_W-1:0]        step_count;
        logic                     diverged;
        logic signed [DATA_W-1:0] value_after_two;
        logic                     after_two_valid;
        logic signed [DATA_W-1:0] value_after_ten;
        logic                     after_ten_valid;
        logic                     divide_by_zero;
    } result_t;

    typedef struct packed {
        logic                method_select;
        logic [THRESH_W-1:0] stop_threshold;
        logic [STEP_W-1:0]   step_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/isr_regs.sv]
`default_nettype none

module isr_regs
    import isr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic                 method_reg;
    logic [THRESH_W-1:0]  thresh_reg;
    logic [STEP_W-1:0]    limit_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METHOD_RST;
            thresh_reg <= THRESH_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_METHOD: method_reg <= pwdata[0];
                REG_THRESH: thresh_reg <= pwdata[THRESH_W-1:0];
                REG_LIMIT:  limit_reg  <= pwdata[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_METHOD: prdata = {{(APB_DATA_W-1){1'b0}}, method_reg};
            REG_THRESH: prdata = {{(APB_DATA_W-THRESH_W){1'b0}}, thresh_reg};
            REG_LIMIT:  prdata = {{(APB_DATA_W-STEP_W){1'b0}}, limit_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.method_select  = method_reg;
    assign cfg.stop_threshold = thresh_reg;
    assign cfg.step_limit     = limit_reg;

endmodule

`default_nettype wire

[rtl/isr_div.sv]
`default_nettype none

module isr_div
    import isr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [DATA_W-1:0]                 dividend,
    input  wire logic [DATA_W-1:0]                 divisor,
    output logic                                   done,
    output logic      [DATA_W+FRACTION_BITS-1:0]   quotient
);

    localparam int N     = DATA_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]      work_reg;
    logic [N-1:0]      work_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] trial;
    logic              fits;

    // shift one dividend bit into the partial remainder, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg[DATA_W-2:0], work_reg[N-1]};
        fits      = (trial >= div_reg);
        rem_next  = fits ? (trial - div_reg) : trial;
        work_next = {work_reg[N-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {dividend, {FRACTION_BITS{1'b0}}};
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

[rtl/iterative_square_root_unit.sv]
// channel   direction  handshake                    word
// --------  ---------  ---------------------------  ----------------------------------
// operand   in         operand_valid/operand_stall  radicand, start_value
// result    out        result_valid/result_stall    estimate, counts, captures, flags
// config    in         APB psel/penable/pwrite      method, threshold, step limit
//
// One step runs S_STEP, S_DIV, S_SCALE, S_AVG (Heron only), S_EVAL and S_TEST; S_DIV
// waits on the bit-serial divider for n/x. A word runs at most step_limit steps.
// A new operand is taken only while the sequencer is idle; a finished result
// sits in the output register until result_stall is low.
// Reset clears the sequencer, the output valid and the registers to their defaults.
`default_nettype none

module iterative_square_root_unit
    import isr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  operand_valid,
    output logic                       operand_stall,
    input  wire operand_t              operand,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    localparam int N = DATA_W + FRACTION_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DIV,
        S_SCALE,
        S_AVG,
        S_EVAL,
        S_TEST,
        S_FINISH
    } state_t;

    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    cfg_t                     cfg;
    state_t                   state_reg;
    logic signed [DATA_W-1:0] n_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] prev_reg;
    logic [DATA_W:0]          diff_reg;
    logic                     neg_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic                     grow_reg;
    logic signed [DATA_W-1:0] two_reg;
    logic signed [DATA_W-1:0] ten_reg;
    logic                     dz_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic                     accept;
    logic                     div_start;
    logic                     div_done;
    logic [N-1:0]             quotient;
    logic [N-1:0]             lim;
    logic [DATA_W-1:0]        q_sat;
    logic [DATA_W-1:0]        scaled;
    logic [DATA_W:0]          sum;
    logic [DATA_W:0]          diff;
    logic [DATA_W:0]          delta;
    logic                     grows;
    logic [STEP_W-1:0]        steps_inc;
    logic                     out_free;

    isr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isr_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_of(n_reg)),
        .divisor  (mag_of(x_reg)),
        .done     (div_done),
        .quotient (quotient)
    );

    assign operand_stall = (state_reg != S_IDLE);
    assign accept        = operand_valid && !operand_stall;
    assign div_start     = (state_reg == S_STEP) && (steps_reg < cfg.step_limit)
                           && (x_reg != '0);
    assign out_free      = !result_valid_reg || !result_stall;

    always_comb
    begin
        lim = neg_reg ? {{FRACTION_BITS{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}
                      : {{FRACTION_BITS{1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
        q_sat     = (quotient > lim) ? lim[DATA_W-1:0] : quotient[DATA_W-1:0];
        scaled    = neg_reg ? (~q_sat + 1'b1) : q_sat;
        sum       = {x_reg[DATA_W-1], x_reg} + {prev_reg[DATA_W-1], prev_reg};
        diff      = {x_reg[DATA_W-1], x_reg} - {prev_reg[DATA_W-1], prev_reg};
        delta     = diff_reg[DATA_W] ? (~diff_reg + 1'b1) : diff_reg;
        grows     = mag_of(x_reg) > mag_of(prev_reg);
        steps_inc = steps_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            steps_reg        <= '0;
            grow_reg         <= 1'b0;
            dz_reg           <= 1'b0;
            two_reg          <= '0;
            ten_reg          <= '0;
            x_reg            <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg     <= operand.radicand;
                        x_reg     <= operand.start_value;
                        steps_reg <= '0;
                        grow_reg  <= 1'b0;
                        dz_reg    <= 1'b0;
                        two_reg   <= '0;
                        ten_reg   <= '0;
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (steps_reg >= cfg.step_limit)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (x_reg == '0)
                    begin
                        dz_reg    <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        prev_reg  <= x_reg;
                        neg_reg   <= n_reg[DATA_W-1] ^ x_reg[DATA_W-1];
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    x_reg     <= scaled;
                    state_reg <= (cfg.method_select == METHOD_HERON) ? S_AVG : S_EVAL;
                end
                S_AVG:
                begin
                    x_reg     <= sum[DATA_W:1];
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (grows)
                    begin
                        grow_reg <= 1'b1;
                    end
                    diff_reg  <= diff;
                    steps_reg <= steps_inc;
                    if (steps_inc == CAPTURE_FIRST)
                    begin
                        two_reg <= x_reg;
                    end
                    if (steps_inc == CAPTURE_SECOND)
                    begin
                        ten_reg <= x_reg;
                    end
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (delta < {{(DATA_W+1-THRESH_W){1'b0}}, cfg.stop_threshold})
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        result_reg.estimate        <= x_reg;
                        result_reg.step_count      <= steps_reg;
                        result_reg.diverged        <= grow_reg;
                        result_reg.value_after_two <= two_reg;
                        result_reg.after_two_valid <= (steps_reg >= CAPTURE_FIRST);
                        result_reg.value_after_ten <= ten_reg;
                        result_reg.after_ten_valid <= (steps_reg >= CAPTURE_SECOND);
                        result_reg.divide_by_zero  <= dz_reg;
                        result_valid_reg           <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (steps_reg <= cfg.step_limit))
        else $error("step count passed the limit");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_zero_flag_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.divide_by_zero) |-> (result_reg.estimate == '0))
        else $error("zero divisor flag with nonzero estimate");

    a_capture_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.after_ten_valid) |-> result_reg.after_two_valid)
        else $error("tenth capture valid without second");

endmodule

`default_nettype wire
